// ----- hw/rtl/qtss_pkg.sv -----
// Shared types and constants for the size-ordered job table.
package qtss_pkg;

    // Default table capacity
    localparam int TABLE_DEPTH_DEF = 64;

    // Payload field widths
    localparam int TAG_W  = 16;
    localparam int SIZE_W = 32;

    // Request kinds carried on s_tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // One table entry: size in the upper bits, tag in the lower bits
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // One result item handed from the sequencer to the output stage
    typedef struct packed {
        entry_t entry;
        logic   table_empty;
        logic   overflowed;
        logic   last_item;
    } result_t;

endpackage

// ----- hw/rtl/queue_table_size_sorter_unit.sv -----
// Top level: stream ports, request decode and the output register stage.
//
// Collects jobs (tag and byte size) into a table, then on a finish request
// sorts them by ascending size and streams them out.
// Input channel s_*: s_tuser[0] is the request kind (0 insert, 1 finish);
// s_tdata carries the tag and size of an insert. Output channel m_*:
// m_tdata carries tag and size, m_tuser the empty and overflow flags, and
// m_tlast marks the final result of a run.
// Inserts can be accepted back to back. Inserts into a full table are
// dropped and set the overflow flag.
// A finish on two or more entries runs an exchange pass over the table, one
// compare per cycle, set by the single read port of the entry store. Each
// result is then read from the store and captured before it is handed on.
// A finish on an empty table yields one result marked empty.
// No new request is taken until the last result of a run sits in the output
// register; the register keeps its result while m_tready is low and the
// sequencer waits behind it.
// Reset empties the table and clears the overflow flag; the store contents
// are not cleared and need no clearing pass.
module queue_table_size_sorter_unit #(
    parameter int TABLE_DEPTH = qtss_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] entry_tag, [47:16] entry_size
    input  logic [0:0]  s_tuser,   // [0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] out_tag, [47:16] out_size
    output logic [1:0]  m_tuser,   // [0] table_empty, [1] overflowed
    output logic        m_tlast    // last_item
);
    import qtss_pkg::*;

    entry_t  req_entry;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;

    assign req_entry = '{size: s_tdata[TAG_W +: SIZE_W], tag: s_tdata[TAG_W-1:0]};

    qtss_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_type  (s_tuser[0]),
        .req_entry (req_entry),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: loads when empty or when its result leaves this cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.entry.size, out_reg.entry.tag};
    assign m_tuser  = {out_reg.overflowed, out_reg.table_empty};
    assign m_tlast  = out_reg.last_item;

    // A result handed over always shows up on the port next cycle
    a_handover: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> m_tvalid)
        else $error("handed-over result missing from output");

    // An empty-table result carries zero payload and closes its run
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && m_tlast))
        else $error("empty result with payload or without last");

    // No new request is taken while a result is still being handed over
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("request accepted while results pending");

endmodule

// ----- hw/rtl/qtss_table.sv -----
// Entry store: one write port and one read port with registered read data.
module qtss_table #(
    parameter int TABLE_DEPTH = qtss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  qtss_pkg::entry_t               wr_data,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output qtss_pkg::entry_t               rd_data
);
    import qtss_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/qtss_seq.sv -----
// Sequencer: inserts, in-place exchange sort over the store, and ordered readout.
module qtss_seq #(
    parameter int TABLE_DEPTH = qtss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // request side
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic                    req_type,
    input  qtss_pkg::entry_t        req_entry,
    // result side
    output logic                    res_valid,
    input  logic                    res_ready,
    output qtss_pkg::result_t       res
);
    import qtss_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_I,
        ST_LOAD_CAP,
        ST_SCAN,
        ST_WB_I,
        ST_EMIT_RD,
        ST_EMIT_CAP,
        ST_EMPTY
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   p_reg, p_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    entry_t             cur_reg, cur_next;

    // table port
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    entry_t             mem_rdata;
    logic               emit_last;

    qtss_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign emit_last = ((k_reg + CNT_W'(1)) == count_reg);

    // Next-state and table access logic
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        cur_next   = cur_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = cur_reg;
        mem_raddr  = '0;
        res_valid  = 1'b0;
        res        = '{entry: mem_rdata, table_empty: 1'b0,
                       overflowed: ovf_reg, last_item: emit_last};

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    if (req_type == REQ_INSERT) begin
                        // store at the fill position, or drop and flag when full
                        if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[IDX_W-1:0];
                            mem_wdata  = req_entry;
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else begin
                        priority if (count_reg == '0) begin
                            state_next = ST_EMPTY;
                        end else if (count_reg == CNT_W'(1)) begin
                            k_next     = '0;
                            state_next = ST_EMIT_RD;
                        end else begin
                            i_next     = '0;
                            state_next = ST_LOAD_I;
                        end
                    end
                end
            end
            ST_LOAD_I: begin
                mem_raddr  = i_reg[IDX_W-1:0];
                state_next = ST_LOAD_CAP;
            end
            ST_LOAD_CAP: begin
                // hold entry i in a register, start streaming p = i+1 ..
                cur_next   = mem_rdata;
                mem_raddr  = IDX_W'(i_reg + CNT_W'(1));
                p_next     = i_reg + CNT_W'(1);
                j_next     = i_reg + CNT_W'(2);
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // compare held entry against entry p; exchange when larger
                if (cur_reg.size > mem_rdata.size) begin
                    mem_we    = 1'b1;
                    mem_waddr = p_reg[IDX_W-1:0];
                    mem_wdata = cur_reg;
                    cur_next  = mem_rdata;
                end
                if (j_reg < count_reg) begin
                    mem_raddr = j_reg[IDX_W-1:0];
                    p_next    = j_reg;
                    j_next    = j_reg + CNT_W'(1);
                end else begin
                    state_next = ST_WB_I;
                end
            end
            ST_WB_I: begin
                // position i now holds the minimum of the remaining entries
                mem_we    = 1'b1;
                mem_waddr = i_reg[IDX_W-1:0];
                mem_wdata = cur_reg;
                i_next    = i_reg + CNT_W'(1);
                if ((i_reg + CNT_W'(2)) < count_reg) begin
                    state_next = ST_LOAD_I;
                end else begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                mem_raddr  = k_reg[IDX_W-1:0];
                state_next = ST_EMIT_CAP;
            end
            ST_EMIT_CAP: begin
                // keep reading the same address so the data holds while stalled
                mem_raddr = k_reg[IDX_W-1:0];
                res_valid = 1'b1;
                if (res_ready) begin
                    if (emit_last) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EMPTY: begin
                res_valid = 1'b1;
                res       = '{entry: '0, table_empty: 1'b1,
                              overflowed: ovf_reg, last_item: 1'b1};
                if (res_ready) begin
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and sequencing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
        i_reg   <= i_next;
        j_reg   <= j_next;
        p_reg   <= p_next;
        k_reg   <= k_next;
        cur_reg <= cur_next;
    end

    // Fill count stays within capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table capacity");

    // In idle the table is written only by an accepted insert
    a_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == ST_IDLE) |-> (req_valid && req_type == REQ_INSERT))
        else $error("table write in idle without an insert");

    // The final result of a run empties the table and clears the flag
    a_run_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready && res.last_item) |=> (count_reg == '0 && !ovf_reg))
        else $error("table not cleared after the final result");

    // Exchange pass only runs on tables of two or more entries
    a_sort_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (count_reg >= CNT_W'(2)))
        else $error("sort pass on a table of fewer than two entries");

endmodule
